### src/vdrh_pkg.sv
// ----------------------------------------------------------------------------
// vdrh_pkg: shared types and constants for the v-disparity row histogram
// Bin geometry, command codes, RAM write bundle and output queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vdrh_pkg;

    localparam int BIN_W       = 8;
    localparam int ADDR_W      = 8;
    localparam int NUM_BINS    = 256;
    localparam logic [BIN_W-1:0] BIN_MAX     = 8'd255;
    localparam logic [BIN_W-1:0] LIMIT_RESET = 8'd250;

    // Command carried in tuser
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BIN_W-1:0]  data;
    } bin_wr_t;

endpackage

### src/vdrh_bin_ram.sv
// ----------------------------------------------------------------------------
// vdrh_bin_ram: histogram bin storage
// 256 x 8 RAM with registered read, per-entry valid flags cleared at reset,
// and a bypass for a read that meets a write to the same bin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdrh_bin_ram
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [vdrh_pkg::ADDR_W-1:0]  rd_addr,
    output logic [vdrh_pkg::BIN_W-1:0]   rd_data,
    input  vdrh_pkg::bin_wr_t            wr
);

    logic [vdrh_pkg::BIN_W-1:0]  mem [vdrh_pkg::NUM_BINS];
    logic [vdrh_pkg::NUM_BINS-1:0] vld_reg;

    logic [vdrh_pkg::BIN_W-1:0]  mem_q_reg;
    logic                        vld_q_reg;
    logic                        byp_reg;
    logic [vdrh_pkg::BIN_W-1:0]  byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            byp_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg <= vld_reg[rd_addr];
                byp_reg   <= wr.en && (wr.addr == rd_addr);
            end
        end
    end

    // never-written bin reads as zero
    always_comb
    begin
        if (byp_reg)
        begin
            rd_data = byp_data_reg;
        end
        else if (vld_q_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

### src/vdrh_out_queue.sv
// ----------------------------------------------------------------------------
// vdrh_out_queue: result queue
// Four-entry register FIFO holding read results for the master side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdrh_out_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [vdrh_pkg::BIN_W-1:0]   push_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [vdrh_pkg::BIN_W-1:0]   out_data,
    output logic [vdrh_pkg::QCNT_W-1:0]  level
);

    logic [vdrh_pkg::BIN_W-1:0]  q_reg [vdrh_pkg::QUEUE_DEPTH];
    logic [vdrh_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [vdrh_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [vdrh_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                        pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_reg[rptr_reg];
    assign level     = cnt_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop  ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + {{(vdrh_pkg::QCNT_W-1){1'b0}}, push}
                            - {{(vdrh_pkg::QCNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // no push into a full queue unless one leaves
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (cnt_reg == vdrh_pkg::QCNT_W'(vdrh_pkg::QUEUE_DEPTH))) |-> pop)
        else $error("result queue overflow");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= vdrh_pkg::QCNT_W'(vdrh_pkg::QUEUE_DEPTH))
        else $error("result queue count out of range");

endmodule

### src/v_disparity_row_histogram.sv
// ----------------------------------------------------------------------------
// v_disparity_row_histogram: per-row depth histogram for a v-disparity map
// A read's count goes via the RAM read register and stage 1 to the queue.
// Throughput: one request per cycle while s_tready is high, set by the
// single bin RAM port pair (read at accept, write next cycle, same-bin
// bypass). Reset: async active-low; all 256 bins read zero right after
// reset via per-bin valid flags, depth_limit returns to 250. No clearing sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v_disparity_row_histogram
(
    input  logic                        clk,
    input  logic                        rst_n,
    // config: depth_limit
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [7:0]                  cfg_data,
    // request stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [7:0] depth, [15:8] bin_index
    input  logic                        s_tuser,   // [0] cmd
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [7:0] count
);

    logic                          accept;
    logic                          in_cmd;
    logic [vdrh_pkg::BIN_W-1:0]    in_depth;
    logic [vdrh_pkg::ADDR_W-1:0]   in_bin;
    logic [vdrh_pkg::ADDR_W-1:0]   rd_addr;

    logic [vdrh_pkg::BIN_W-1:0]    limit_reg;

    // stage 1: request waiting on RAM read data
    logic                          s1_valid_reg;
    logic                          s1_cmd_reg;
    logic [vdrh_pkg::ADDR_W-1:0]   s1_addr_reg;

    logic [vdrh_pkg::BIN_W-1:0]    old_count;
    vdrh_pkg::bin_wr_t             wr;
    logic                          push;
    logic                          s1_rd;
    logic [vdrh_pkg::QCNT_W-1:0]   q_level;
    logic [vdrh_pkg::QCNT_W-1:0]   pending;

    assign in_cmd   = s_tuser;
    assign in_depth = s_tdata[7:0];
    assign in_bin   = s_tdata[15:8];
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = (in_cmd == vdrh_pkg::CMD_READ) ? in_bin : in_depth;

    // Space in the queue is reserved for every read in flight, so stage 1
    // never stalls and the RMW order is fixed by acceptance order.
    assign s1_rd    = s1_valid_reg && (s1_cmd_reg == vdrh_pkg::CMD_READ);
    assign pending  = q_level + {{(vdrh_pkg::QCNT_W-1){1'b0}}, s1_rd};
    assign s_tready = (pending < vdrh_pkg::QCNT_W'(vdrh_pkg::QUEUE_DEPTH));

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= vdrh_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= in_cmd;
            s1_addr_reg <= rd_addr;
        end
    end

    vdrh_bin_ram u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (old_count),
        .wr      (wr)
    );

    // Read-modify-write: a read clears the bin, an accumulate below the
    // limit bumps it unless already saturated.
    always_comb
    begin
        wr.addr = s1_addr_reg;
        if (s1_cmd_reg == vdrh_pkg::CMD_READ)
        begin
            wr.en   = s1_valid_reg;
            wr.data = '0;
        end
        else
        begin
            wr.en   = s1_valid_reg && (s1_addr_reg < limit_reg)
                      && (old_count != vdrh_pkg::BIN_MAX);
            wr.data = old_count + 1'b1;
        end
    end

    assign push = s1_rd;

    vdrh_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (old_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .level     (q_level)
    );

    a_s1_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request did not reach stage 1");

    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_rd |=> m_tvalid)
        else $error("read request produced no result");

endmodule
